// ===== sv/act_pkg.sv =====
// shared types and constants for the alarm clock timekeeper
// item structs, internal state record, command codes and reset values; no dependencies
package act_pkg;

    localparam logic [2:0] CMD_TICK         = 3'd0;
    localparam logic [2:0] CMD_TOGGLE_24H   = 3'd1;
    localparam logic [2:0] CMD_TOGGLE_ALARM = 3'd2;
    localparam logic [2:0] CMD_SNOOZE       = 3'd3;
    localparam logic [2:0] CMD_SILENCE      = 3'd4;
    localparam logic [2:0] CMD_SET_TIME     = 3'd5;
    localparam logic [2:0] CMD_SET_ALARM    = 3'd6;

    localparam logic CFG_TICKS_PER_SECOND = 1'b0;
    localparam logic CFG_SNOOZE_SECONDS   = 1'b1;

    localparam logic [7:0] TICKS_PER_SECOND_RST = 8'd128;
    localparam logic [7:0] SNOOZE_SECONDS_RST   = 8'd10;
    localparam logic [4:0] HOUR_RST             = 5'd12;

    localparam logic [5:0] MINUTE_MAX     = 6'd59;
    localparam logic [5:0] SIXTY          = 6'd60;
    localparam logic [4:0] HOUR_12H_MAX   = 5'd12;
    localparam logic [4:0] HOUR_12H_WRAP  = 5'd13;
    localparam logic [4:0] HOUR_24H_MAX   = 5'd23;
    localparam logic [4:0] HOURS_PER_DAY  = 5'd24;

    typedef struct packed {
        logic [2:0] command;
        logic [4:0] hour_value;
        logic [5:0] minute_value;
        logic       pm_value;
    } t_in_item;

    typedef struct packed {
        logic [4:0] hour_now;
        logic [5:0] minute_now;
        logic [5:0] second_now;
        logic       pm_now;
        logic       mode_24h;
        logic       alarm_enabled;
        logic       alarm_ringing;
        logic       snooze_active;
        logic       status_changed;
    } t_out_item;

    typedef struct packed {
        logic [7:0] ticks_per_second;
        logic [7:0] snooze_seconds;
    } t_cfg;

    typedef struct packed {
        logic [7:0] tick_count;
        logic [5:0] second;
        logic [5:0] minute;
        logic [4:0] hour;
        logic       pm;
        logic       mode_24h;
        logic [4:0] alarm_hour;
        logic [5:0] alarm_minute;
        logic       alarm_pm;
        logic       alarm_enable;
        logic       ringing;
        logic       match_latched;
        logic       snooze_run;
        logic [7:0] snooze_count;
    } t_state;

endpackage

// ===== sv/act_step.sv =====
// next-state and result logic for one item of the alarm clock timekeeper
// purely combinational; depends on act_pkg
module act_step (
    input  act_pkg::t_state    i_state,
    input  act_pkg::t_cfg      i_cfg,
    input  act_pkg::t_in_item  i_item,
    output act_pkg::t_state    o_state,
    output act_pkg::t_out_item o_result
);

    function automatic logic [4:0] mod12(input logic [4:0] h);
        logic [4:0] r;
        r = h;
        if (r >= act_pkg::HOURS_PER_DAY) r = r - act_pkg::HOURS_PER_DAY;
        if (r >= act_pkg::HOUR_12H_MAX)  r = r - act_pkg::HOUR_12H_MAX;
        return r;
    endfunction

    logic [4:0] w_hour;
    logic [5:0] w_minute;
    logic       w_pm;
    logic       w_match;

    // saturated time as written by set time or set alarm
    always_comb begin
        w_minute = (i_item.minute_value > act_pkg::MINUTE_MAX) ?
                   act_pkg::MINUTE_MAX : i_item.minute_value;
        if (i_state.mode_24h) begin
            w_hour = (i_item.hour_value > act_pkg::HOUR_24H_MAX) ?
                     act_pkg::HOUR_24H_MAX : i_item.hour_value;
            w_pm   = 1'b0;
        end else begin
            w_hour = (i_item.hour_value == 5'd0 ||
                      i_item.hour_value > act_pkg::HOUR_12H_MAX) ?
                     act_pkg::HOUR_12H_MAX : i_item.hour_value;
            w_pm   = i_item.pm_value;
        end
    end

    always_comb begin
        act_pkg::t_state s;
        s = i_state;
        case (i_item.command)
            act_pkg::CMD_TICK: begin
                s.tick_count = s.tick_count + 8'd1;
                if (s.tick_count >= i_cfg.ticks_per_second) begin
                    s.tick_count = 8'd0;
                    if (s.snooze_run) s.snooze_count = s.snooze_count + 8'd1;
                    s.second = s.second + 6'd1;
                    if (s.second >= act_pkg::SIXTY) begin
                        s.second = 6'd0;
                        s.minute = s.minute + 6'd1;
                        if (s.minute >= act_pkg::SIXTY) begin
                            s.minute = 6'd0;
                            s.hour   = s.hour + 5'd1;
                            if (s.mode_24h) begin
                                if (s.hour >= act_pkg::HOURS_PER_DAY) s.hour = 5'd0;
                            end else begin
                                if (s.hour == act_pkg::HOUR_12H_MAX) s.pm = ~s.pm;
                                if (s.hour >= act_pkg::HOUR_12H_WRAP)
                                    s.hour = s.hour - act_pkg::HOUR_12H_MAX;
                            end
                        end
                    end
                end
            end
            act_pkg::CMD_TOGGLE_24H: begin
                if (!s.mode_24h) begin
                    s.hour     = mod12(s.hour) + (s.pm ? act_pkg::HOUR_12H_MAX : 5'd0);
                    s.pm       = 1'b0;
                    s.mode_24h = 1'b1;
                end else begin
                    s.pm       = (s.hour >= act_pkg::HOUR_12H_MAX);
                    s.hour     = mod12(s.hour);
                    if (s.hour == 5'd0) s.hour = act_pkg::HOUR_12H_MAX;
                    s.mode_24h = 1'b0;
                end
            end
            act_pkg::CMD_TOGGLE_ALARM: begin
                s.alarm_enable = ~s.alarm_enable;
            end
            act_pkg::CMD_SNOOZE: begin
                if (s.ringing) begin
                    s.ringing      = 1'b0;
                    s.snooze_run   = 1'b1;
                    s.snooze_count = 8'd0;
                end
            end
            act_pkg::CMD_SILENCE: begin
                s.ringing = 1'b0;
            end
            act_pkg::CMD_SET_TIME: begin
                s.hour   = w_hour;
                s.minute = w_minute;
                s.pm     = w_pm;
            end
            act_pkg::CMD_SET_ALARM: begin
                s.alarm_hour   = w_hour;
                s.alarm_minute = w_minute;
                s.alarm_pm     = w_pm;
            end
            default: begin
            end
        endcase

        w_match = (s.minute == s.alarm_minute) && (s.hour == s.alarm_hour) &&
                  (s.pm == s.alarm_pm);
        if (w_match) begin
            if (!s.match_latched && s.alarm_enable) begin
                s.ringing       = 1'b1;
                s.match_latched = 1'b1;
            end
        end else begin
            s.ringing       = 1'b0;
            s.match_latched = 1'b0;
        end

        // snooze expiry re-arms at the current time
        if (s.snooze_run && s.snooze_count >= i_cfg.snooze_seconds) begin
            s.ringing      = 1'b1;
            s.snooze_run   = 1'b0;
            s.snooze_count = 8'd0;
            s.alarm_minute = s.minute;
            s.alarm_hour   = s.hour;
        end

        o_state                 = s;
        o_result.hour_now       = s.hour;
        o_result.minute_now     = s.minute;
        o_result.second_now     = s.second;
        o_result.pm_now         = s.pm;
        o_result.mode_24h       = s.mode_24h;
        o_result.alarm_enabled  = s.alarm_enable;
        o_result.alarm_ringing  = s.ringing;
        o_result.snooze_active  = s.snooze_run;
        o_result.status_changed = (s.ringing != i_state.ringing) ||
                                  (s.snooze_run != i_state.snooze_run) ||
                                  (s.alarm_enable != i_state.alarm_enable);
    end

endmodule

// ===== sv/alarm_clock_timekeeper_core.sv =====
// top level of the alarm clock timekeeper: state, configuration and output buffering
// depends on act_pkg and act_step
//
// One event item is taken per clock cycle while input ready is high, and gives exactly one
// result item, which is registered into the output buffer; the whole update of the
// time, alarm and snooze state is one pass of logic between the state register and the
// result register. A two-entry output buffer lets the block keep taking items while a
// result waits, so input ready drops only when both entries are full. Configuration
// writes are always accepted and apply to the next item.
module alarm_clock_timekeeper_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  act_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output act_pkg::t_out_item o_out_item,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [7:0]         i_cfg_data
);

    act_pkg::t_state    r_state;
    act_pkg::t_state    n_state;
    act_pkg::t_state    w_state_rst;
    act_pkg::t_cfg      r_cfg;
    act_pkg::t_out_item n_result;
    act_pkg::t_out_item r_out;
    act_pkg::t_out_item r_skid;
    logic               r_out_valid;
    logic               r_skid_valid;
    logic               w_accept;
    logic               w_taken;

    assign o_in_ready  = !r_skid_valid;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_taken     = r_out_valid && i_out_ready;

    // state after reset: all zero except the hour
    always_comb begin
        w_state_rst      = '0;
        w_state_rst.hour = act_pkg::HOUR_RST;
    end

    act_step u_step (
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .i_item   (i_in_item),
        .o_state  (n_state),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ticks_per_second <= act_pkg::TICKS_PER_SECOND_RST;
            r_cfg.snooze_seconds   <= act_pkg::SNOOZE_SECONDS_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                act_pkg::CFG_TICKS_PER_SECOND: r_cfg.ticks_per_second <= i_cfg_data;
                act_pkg::CFG_SNOOZE_SECONDS:   r_cfg.snooze_seconds   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= w_state_rst;
        end else if (w_accept) begin
            r_state <= n_state;
        end
    end

    // two-entry output buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_taken) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= w_accept;
            end
        end else if (w_accept) begin
            if (r_out_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_taken) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (w_accept) begin
                r_out <= n_result;
            end
        end else if (w_accept) begin
            if (r_out_valid) begin
                r_skid <= n_result;
            end else begin
                r_out <= n_result;
            end
        end
    end

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without a head entry");

    a_stall_fills_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready && w_accept) |=> r_skid_valid)
        else $error("item accepted under stall was not buffered");

    a_hour_12h: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_state.mode_24h |-> (r_state.hour != 5'd0 &&
                               r_state.hour <= act_pkg::HOUR_12H_MAX))
        else $error("12-hour mode hour out of range");

    a_hour_24h: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.mode_24h |-> (r_state.hour <= act_pkg::HOUR_24H_MAX && !r_state.pm))
        else $error("24-hour mode hour or pm flag out of range");

    a_min_sec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.minute < act_pkg::SIXTY && r_state.second < act_pkg::SIXTY)
        else $error("minute or second out of range");

endmodule

// ===== verif/alarm_clock_timekeeper_core_test.sv =====
`timescale 1ns / 100ps
// self-checking bench for alarm_clock_timekeeper_core: directed table, then random event phases
// predicts results the table does not list from its model; depends on act_pkg and the core only
module alarm_clock_timekeeper_core_test;

    localparam logic [2:0]  CMD_UNUSED    = 3'd7;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned QUIET_LIMIT   = 3000;
    localparam int unsigned PHASE_COUNT   = 6;
    localparam int unsigned PHASE_ITEMS   = 105;
    localparam int unsigned IDLE_SPLIT_A  = 240;
    localparam int unsigned IDLE_SPLIT_B  = 480;
    localparam int unsigned SPARSE_PCT    = 18;
    localparam int unsigned DENSE_PCT     = 87;

    typedef enum logic [1:0] {ROW_EVENT, ROW_KNOWN, ROW_REG} t_row_kind;

    typedef struct packed {
        logic [7:0] tick_cnt;
        logic [5:0] sec;
        logic [5:0] min;
        logic [4:0] hr;
        logic       pm;
        logic       mode24;
        logic [4:0] al_hr;
        logic [5:0] al_min;
        logic       al_pm;
        logic       al_en;
        logic       ring;
        logic       latched;
        logic       snz_run;
        logic [7:0] snz_cnt;
    } t_clock_model;

    typedef struct {
        t_row_kind          kind;
        act_pkg::t_in_item  ev;
        logic               reg_idx;
        logic [7:0]         reg_val;
        act_pkg::t_out_item want;
    } t_drill_row;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    act_pkg::t_in_item  in_item = '0;
    logic               out_ready = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_index = 1'b0;
    logic [7:0]         cfg_data = '0;
    logic               o_in_ready;
    logic               o_out_valid;
    act_pkg::t_out_item o_out_item;
    logic               o_cfg_ready;

    t_clock_model       clock_now;
    logic [7:0]         tick_div;
    logic [7:0]         snooze_len;
    act_pkg::t_out_item pending_readouts[$];
    t_drill_row         drill[$];
    int unsigned        mismatches = 0;
    int unsigned        items_sent = 0;
    int unsigned        quiet_cycles = 0;
    int unsigned        send_idle_pct = SPARSE_PCT;
    int unsigned        recv_idle_pct = DENSE_PCT;

    alarm_clock_timekeeper_core u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void clamp_time(input act_pkg::t_in_item ev, output logic [4:0] h,
                                       output logic [5:0] m, output logic p);
        h = ev.hour_value;
        m = (ev.minute_value > act_pkg::MINUTE_MAX) ? act_pkg::MINUTE_MAX : ev.minute_value;
        if (clock_now.mode24) begin
            if (h > act_pkg::HOUR_24H_MAX) h = act_pkg::HOUR_24H_MAX;
            p = 1'b0;
        end else begin
            if (h == 5'd0 || h > act_pkg::HOUR_12H_MAX) h = act_pkg::HOUR_12H_MAX;
            p = ev.pm_value;
        end
    endfunction

    function automatic act_pkg::t_out_item apply_event(act_pkg::t_in_item ev);
        act_pkg::t_out_item res;
        logic               was_ringing;
        logic               was_snoozing;
        logic               was_enabled;
        was_ringing  = clock_now.ring;
        was_snoozing = clock_now.snz_run;
        was_enabled  = clock_now.al_en;
        case (ev.command)
            act_pkg::CMD_TICK: begin
                clock_now.tick_cnt = clock_now.tick_cnt + 8'd1;
                if (clock_now.tick_cnt >= tick_div) begin
                    clock_now.tick_cnt = '0;
                    if (clock_now.snz_run) clock_now.snz_cnt = clock_now.snz_cnt + 8'd1;
                    clock_now.sec = clock_now.sec + 6'd1;
                    if (clock_now.sec >= act_pkg::SIXTY) begin
                        clock_now.sec = '0;
                        clock_now.min = clock_now.min + 6'd1;
                        if (clock_now.min >= act_pkg::SIXTY) begin
                            clock_now.min = '0;
                            clock_now.hr = clock_now.hr + 5'd1;
                            if (clock_now.mode24) begin
                                if (clock_now.hr >= act_pkg::HOURS_PER_DAY) clock_now.hr = '0;
                            end else begin
                                if (clock_now.hr == act_pkg::HOUR_12H_MAX)
                                    clock_now.pm = ~clock_now.pm;
                                if (clock_now.hr >= act_pkg::HOUR_12H_WRAP)
                                    clock_now.hr = clock_now.hr - act_pkg::HOUR_12H_MAX;
                            end
                        end
                    end
                end
            end
            act_pkg::CMD_TOGGLE_24H: begin
                if (!clock_now.mode24) begin
                    clock_now.hr = (clock_now.hr % act_pkg::HOUR_12H_MAX)
                                   + (clock_now.pm ? act_pkg::HOUR_12H_MAX : 5'd0);
                    clock_now.pm = 1'b0;
                    clock_now.mode24 = 1'b1;
                end else begin
                    clock_now.pm = (clock_now.hr >= act_pkg::HOUR_12H_MAX);
                    clock_now.hr = clock_now.hr % act_pkg::HOUR_12H_MAX;
                    if (clock_now.hr == 5'd0) clock_now.hr = act_pkg::HOUR_12H_MAX;
                    clock_now.mode24 = 1'b0;
                end
            end
            act_pkg::CMD_TOGGLE_ALARM: clock_now.al_en = ~clock_now.al_en;
            act_pkg::CMD_SNOOZE: begin
                if (clock_now.ring) begin
                    clock_now.ring = 1'b0;
                    clock_now.snz_run = 1'b1;
                    clock_now.snz_cnt = '0;
                end
            end
            act_pkg::CMD_SILENCE: clock_now.ring = 1'b0;
            act_pkg::CMD_SET_TIME:
                clamp_time(ev, clock_now.hr, clock_now.min, clock_now.pm);
            act_pkg::CMD_SET_ALARM:
                clamp_time(ev, clock_now.al_hr, clock_now.al_min, clock_now.al_pm);
            default: ;
        endcase

        if (clock_now.min == clock_now.al_min && clock_now.hr == clock_now.al_hr
                && clock_now.pm == clock_now.al_pm) begin
            if (!clock_now.latched && clock_now.al_en) begin
                clock_now.ring = 1'b1;
                clock_now.latched = 1'b1;
            end
        end else begin
            clock_now.ring = 1'b0;
            clock_now.latched = 1'b0;
        end

        // snooze expiry re-arms the alarm at the time now
        if (clock_now.snz_run && clock_now.snz_cnt >= snooze_len) begin
            clock_now.ring = 1'b1;
            clock_now.snz_run = 1'b0;
            clock_now.snz_cnt = '0;
            clock_now.al_min = clock_now.min;
            clock_now.al_hr = clock_now.hr;
        end

        res.hour_now       = clock_now.hr;
        res.minute_now     = clock_now.min;
        res.second_now     = clock_now.sec;
        res.pm_now         = clock_now.pm;
        res.mode_24h       = clock_now.mode24;
        res.alarm_enabled  = clock_now.al_en;
        res.alarm_ringing  = clock_now.ring;
        res.snooze_active  = clock_now.snz_run;
        res.status_changed = (was_ringing != clock_now.ring)
                             || (was_snoozing != clock_now.snz_run)
                             || (was_enabled != clock_now.al_en);
        return res;
    endfunction

    function automatic act_pkg::t_in_item next_event();
        act_pkg::t_in_item ev;
        int unsigned       pick;
        pick = $urandom_range(99);
        ev.command      = act_pkg::CMD_TICK;
        ev.hour_value   = 5'($urandom_range(31));
        ev.minute_value = 6'($urandom_range(63));
        ev.pm_value     = 1'($urandom_range(1));
        if (pick < 44) begin
            ev.command = act_pkg::CMD_TICK;
        end else if (pick < 49) begin
            ev.command = act_pkg::CMD_TOGGLE_24H;
        end else if (pick < 55 || (pick < 61 && !clock_now.al_en)) begin
            ev.command = act_pkg::CMD_TOGGLE_ALARM;
        end else if (pick < 70) begin
            ev.command = act_pkg::CMD_SNOOZE;
        end else if (pick < 75) begin
            ev.command = act_pkg::CMD_SILENCE;
        end else if (pick < 85) begin
            ev.command = act_pkg::CMD_SET_TIME;
            // mostly a legal time, often at minute 59 so rollovers come soon
            if ($urandom_range(2) != 0) begin
                ev.hour_value = clock_now.mode24 ? 5'($urandom_range(23))
                                                 : 5'($urandom_range(12, 1));
                ev.minute_value = $urandom_range(1) ? act_pkg::MINUTE_MAX
                                                    : 6'($urandom_range(59));
            end
        end else if (pick < 97) begin
            ev.command = act_pkg::CMD_SET_ALARM;
            // mostly the time now so the alarm goes off
            if ($urandom_range(3) != 0) begin
                ev.hour_value   = clock_now.hr;
                ev.minute_value = clock_now.min;
                ev.pm_value     = clock_now.pm;
            end
        end else begin
            ev.command = CMD_UNUSED;
        end
        return ev;
    endfunction

    function automatic void add_row(t_row_kind kind, logic [2:0] cmd, logic [4:0] h,
                                    logic [5:0] m, logic p,
                                    act_pkg::t_out_item want = '0);
        t_drill_row row;
        row.kind    = kind;
        row.ev      = {cmd, h, m, p};
        row.reg_idx = 1'b0;
        row.reg_val = '0;
        row.want    = want;
        drill.push_back(row);
    endfunction

    function automatic void add_reg(logic idx, logic [7:0] val);
        t_drill_row row;
        row.kind    = ROW_REG;
        row.ev      = '0;
        row.reg_idx = idx;
        row.reg_val = val;
        row.want    = '0;
        drill.push_back(row);
    endfunction

    task automatic push_event(act_pkg::t_in_item ev, logic known, act_pkg::t_out_item want);
        send_idle_pct = (items_sent < IDLE_SPLIT_A) ? SPARSE_PCT
                      : (items_sent < IDLE_SPLIT_B) ? DENSE_PCT : 0;
        recv_idle_pct = (items_sent < IDLE_SPLIT_A) ? DENSE_PCT
                      : (items_sent < IDLE_SPLIT_B) ? SPARSE_PCT : 0;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= ev;
        @(posedge clk);
        while (!o_in_ready) @(posedge clk);
        items_sent++;
        if (known) begin
            void'(apply_event(ev));
            pending_readouts.push_back(want);
        end else begin
            pending_readouts.push_back(apply_event(ev));
        end
    endtask

    task automatic write_reg(logic idx, logic [7:0] val, logic last);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!o_cfg_ready) @(posedge clk);
        if (last) cfg_valid <= 1'b0;
        if (idx == act_pkg::CFG_TICKS_PER_SECOND) tick_div = val;
        else snooze_len = val;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_readouts.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic check_field(string field, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk) begin : result_check
        act_pkg::t_out_item want;
        if (rst_n && o_out_valid && out_ready) begin
            if (pending_readouts.size() == 0) begin
                $error("result item arrived with nothing expected");
                mismatches++;
            end else begin
                want = pending_readouts.pop_front();
                check_field("hour_now", want.hour_now, o_out_item.hour_now);
                check_field("minute_now", want.minute_now, o_out_item.minute_now);
                check_field("second_now", want.second_now, o_out_item.second_now);
                check_field("pm_now", want.pm_now, o_out_item.pm_now);
                check_field("mode_24h", want.mode_24h, o_out_item.mode_24h);
                check_field("alarm_enabled", want.alarm_enabled, o_out_item.alarm_enabled);
                check_field("alarm_ringing", want.alarm_ringing, o_out_item.alarm_ringing);
                check_field("snooze_active", want.snooze_active, o_out_item.snooze_active);
                check_field("status_changed", want.status_changed, o_out_item.status_changed);
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready)
                || (cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        logic [7:0] tps;
        logic [7:0] snz;
        clock_now  = '0;
        clock_now.hr = act_pkg::HOUR_RST;
        tick_div   = act_pkg::TICKS_PER_SECOND_RST;
        snooze_len = act_pkg::SNOOZE_SECONDS_RST;

        // want columns: hour, minute, second, flags pm/mode/enable/ring/snooze/changed
        add_row(ROW_KNOWN, CMD_UNUSED, 5'd0, 6'd0, 1'b0,
                {5'd12, 6'd0, 6'd0, 6'b000000});
        add_row(ROW_KNOWN, act_pkg::CMD_SNOOZE, 5'd0, 6'd0, 1'b0,
                {5'd12, 6'd0, 6'd0, 6'b000000});
        add_row(ROW_KNOWN, act_pkg::CMD_SILENCE, 5'd0, 6'd0, 1'b0,
                {5'd12, 6'd0, 6'd0, 6'b000000});
        add_row(ROW_KNOWN, act_pkg::CMD_TICK, 5'd31, 6'd63, 1'b1,
                {5'd12, 6'd0, 6'd0, 6'b000000});
        // midnight in 12h mode turns into hour 0
        add_row(ROW_KNOWN, act_pkg::CMD_TOGGLE_24H, 5'd0, 6'd0, 1'b0,
                {5'd0, 6'd0, 6'd0, 6'b010000});
        add_row(ROW_KNOWN, act_pkg::CMD_TOGGLE_ALARM, 5'd0, 6'd0, 1'b0,
                {5'd0, 6'd0, 6'd0, 6'b011101});
        add_row(ROW_KNOWN, act_pkg::CMD_SNOOZE, 5'd0, 6'd0, 1'b0,
                {5'd0, 6'd0, 6'd0, 6'b011011});
        // saturation in 24h mode
        add_row(ROW_KNOWN, act_pkg::CMD_SET_TIME, 5'd31, 6'd63, 1'b1,
                {5'd23, 6'd59, 6'd0, 6'b011010});
        add_row(ROW_KNOWN, act_pkg::CMD_SET_ALARM, 5'd31, 6'd63, 1'b1,
                {5'd23, 6'd59, 6'd0, 6'b011111});
        add_row(ROW_KNOWN, act_pkg::CMD_SILENCE, 5'd0, 6'd0, 1'b0,
                {5'd23, 6'd59, 6'd0, 6'b011011});
        add_row(ROW_KNOWN, act_pkg::CMD_TOGGLE_24H, 5'd0, 6'd0, 1'b0,
                {5'd11, 6'd59, 6'd0, 6'b101010});
        // hour 0 and hours above 12 in 12h mode become 12
        add_row(ROW_KNOWN, act_pkg::CMD_SET_TIME, 5'd0, 6'd0, 1'b1,
                {5'd12, 6'd0, 6'd0, 6'b101010});
        add_row(ROW_KNOWN, act_pkg::CMD_TOGGLE_24H, 5'd0, 6'd0, 1'b0,
                {5'd12, 6'd0, 6'd0, 6'b011010});
        add_row(ROW_KNOWN, act_pkg::CMD_TOGGLE_24H, 5'd0, 6'd0, 1'b0,
                {5'd12, 6'd0, 6'd0, 6'b101010});
        add_row(ROW_KNOWN, act_pkg::CMD_SET_TIME, 5'd31, 6'd0, 1'b0,
                {5'd12, 6'd0, 6'd0, 6'b001010});
        add_row(ROW_EVENT, act_pkg::CMD_SET_ALARM, 5'd13, 6'd5, 1'b1);
        // zero divider and zero snooze length
        add_reg(act_pkg::CFG_TICKS_PER_SECOND, 8'd0);
        add_reg(act_pkg::CFG_SNOOZE_SECONDS, 8'd0);
        add_row(ROW_EVENT, act_pkg::CMD_TICK, 5'd0, 6'd0, 1'b0);
        add_row(ROW_EVENT, act_pkg::CMD_SNOOZE, 5'd0, 6'd0, 1'b0);
        add_row(ROW_EVENT, act_pkg::CMD_SILENCE, 5'd0, 6'd0, 1'b0);
        add_row(ROW_EVENT, act_pkg::CMD_TOGGLE_ALARM, 5'd0, 6'd0, 1'b0);
        add_row(ROW_EVENT, act_pkg::CMD_TOGGLE_ALARM, 5'd0, 6'd0, 1'b0);
        add_row(ROW_EVENT, act_pkg::CMD_TICK, 5'd0, 6'd0, 1'b0);
        add_reg(act_pkg::CFG_TICKS_PER_SECOND, 8'd255);
        add_reg(act_pkg::CFG_SNOOZE_SECONDS, 8'd255);
        add_row(ROW_EVENT, act_pkg::CMD_TICK, 5'd0, 6'd0, 1'b0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (drill[i]) begin
            if (drill[i].kind == ROW_REG) begin
                if (i == 0 || drill[i-1].kind != ROW_REG) drain_results();
                write_reg(drill[i].reg_idx, drill[i].reg_val,
                          i == drill.size() - 1 || drill[i+1].kind != ROW_REG);
            end else begin
                push_event(drill[i].ev, drill[i].kind == ROW_KNOWN, drill[i].want);
            end
        end

        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0: begin tps = 8'd1;   snz = 8'd1;   end
                1: begin tps = 8'd1;   snz = 8'd255; end
                2: begin tps = 8'd0;   snz = 8'd0;   end
                3: begin tps = 8'd255; snz = 8'd2;   end
                4: begin tps = 8'd2;   snz = 8'd3;   end
                default: begin
                    tps = 8'($urandom_range(5, 1));
                    snz = 8'($urandom_range(30, 1));
                end
            endcase
            // config only changes with no result item outstanding
            drain_results();
            write_reg(act_pkg::CFG_TICKS_PER_SECOND, tps, 1'b0);
            write_reg(act_pkg::CFG_SNOOZE_SECONDS, snz, 1'b1);
            repeat (PHASE_ITEMS) push_event(next_event(), 1'b0, '0);
        end

        drain_results();
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== alarm_clock_timekeeper_core.f =====
sv/act_pkg.sv
sv/act_step.sv
sv/alarm_clock_timekeeper_core.sv
verif/alarm_clock_timekeeper_core_test.sv
